/* design/point_in_triangle_test_core_defines.svh */
// Assertion macros for the point-in-triangle test RTL.
`ifndef POINT_IN_TRIANGLE_TEST_CORE_DEFINES_SVH
`define POINT_IN_TRIANGLE_TEST_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property while out of reset.
`define PIT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// Check a property at every edge, reset included.
`define PIT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PIT_ASSERT(lbl, clk, rst_n, prop, msg)
`define PIT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* design/pit_pkg.sv */
// Shared types and codes of the point-in-triangle test pipeline.
package pit_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_TESTED     = 2'd0,
        STATUS_Z_DIFFER   = 2'd1,
        STATUS_DEGENERATE = 2'd2
    } t_status;

    // Control that travels with each pipeline stage
    typedef struct packed {
        logic valid;
        logic z_diff;
    } t_stage_ctl;

endpackage

/* design/pit_in_if.sv */
// Input channel: triangle vertices and query point with valid/ready.
interface pit_in_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] first_z;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
    logic signed [COORD_BITS-1:0] second_z;
    logic signed [COORD_BITS-1:0] third_x;
    logic signed [COORD_BITS-1:0] third_y;
    logic signed [COORD_BITS-1:0] third_z;
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;

    modport source (
        output valid, first_x, first_y, first_z, second_x, second_y, second_z,
               third_x, third_y, third_z, query_x, query_y,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
               third_x, third_y, third_z, query_x, query_y,
        output ready
    );
endinterface

/* design/pit_out_if.sv */
// Output channel: coverage result and status with valid/ready.
interface pit_out_if;
    logic       valid;
    logic       ready;
    logic       inside_res;
    logic [1:0] status;

    modport source (
        output valid, inside_res, status,
        input  ready
    );
    modport sink (
        input  valid, inside_res, status,
        output ready
    );
endinterface

/* design/pit_diff.sv */
// Stage 1: edge vectors relative to the first vertex and height check.
module pit_diff #(
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pit_in_if.sink                        i_in,
    input  logic                          i_ready,
    output pit_pkg::t_stage_ctl           o_ctl,
    output logic signed [COORD_BITS:0]    o_e0x,
    output logic signed [COORD_BITS:0]    o_e0y,
    output logic signed [COORD_BITS:0]    o_e1x,
    output logic signed [COORD_BITS:0]    o_e1y,
    output logic signed [COORD_BITS:0]    o_e2x,
    output logic signed [COORD_BITS:0]    o_e2y
);
    localparam int DW = COORD_BITS + 1;
    localparam int SB = COORD_BITS - 1;

    pit_pkg::t_stage_ctl   r_ctl;
    logic signed [DW-1:0]  r_e0x, r_e0y, r_e1x, r_e1y, r_e2x, r_e2y;
    logic                  w_en;

    // Advance when empty or when the next stage takes the transaction; refuse input in reset
    assign w_en       = !r_ctl.valid || i_ready;
    assign i_in.ready = w_en && i_rst_n;

    // Hold control under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (w_en) begin
            r_ctl.valid  <= i_in.valid;
            r_ctl.z_diff <= (i_in.first_z != i_in.second_z) ||
                            (i_in.second_z != i_in.third_z);
        end
    end

    // Sign-extend and subtract the first vertex
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e0x <= {i_in.third_x[SB], i_in.third_x} - {i_in.first_x[SB], i_in.first_x};
            r_e0y <= {i_in.third_y[SB], i_in.third_y} - {i_in.first_y[SB], i_in.first_y};
            r_e1x <= {i_in.second_x[SB], i_in.second_x} - {i_in.first_x[SB], i_in.first_x};
            r_e1y <= {i_in.second_y[SB], i_in.second_y} - {i_in.first_y[SB], i_in.first_y};
            r_e2x <= {i_in.query_x[SB], i_in.query_x} - {i_in.first_x[SB], i_in.first_x};
            r_e2y <= {i_in.query_y[SB], i_in.query_y} - {i_in.first_y[SB], i_in.first_y};
        end
    end

    assign o_ctl = r_ctl;
    assign o_e0x = r_e0x;
    assign o_e0y = r_e0y;
    assign o_e1x = r_e1x;
    assign o_e1y = r_e1y;
    assign o_e2x = r_e2x;
    assign o_e2y = r_e2y;
endmodule

/* design/pit_mult.sv */
// Stages 2 and 3: cross-product partial products, then the three crosses.
module pit_mult #(
    parameter int COORD_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pit_pkg::t_stage_ctl                 i_ctl,
    input  logic signed [COORD_BITS:0]          i_e0x,
    input  logic signed [COORD_BITS:0]          i_e0y,
    input  logic signed [COORD_BITS:0]          i_e1x,
    input  logic signed [COORD_BITS:0]          i_e1y,
    input  logic signed [COORD_BITS:0]          i_e2x,
    input  logic signed [COORD_BITS:0]          i_e2y,
    output logic                                o_ready,
    input  logic                                i_ready,
    output pit_pkg::t_stage_ctl                 o_ctl,
    output logic signed [2*COORD_BITS+2:0]      o_a,
    output logic signed [2*COORD_BITS+2:0]      o_b,
    output logic signed [2*COORD_BITS+2:0]      o_c
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int CW = PW + 1;

    pit_pkg::t_stage_ctl  r_ctl_p, r_ctl_x;
    logic signed [PW-1:0] r_c0, r_c1, r_a0, r_a1, r_b0, r_b1;
    logic signed [CW-1:0] r_a, r_b, r_c;
    logic                 w_en_p, w_en_x;

    // Per-stage enables collapse bubbles and hold on stall
    assign w_en_x  = !r_ctl_x.valid || i_ready;
    assign w_en_p  = !r_ctl_p.valid || w_en_x;
    assign o_ready = w_en_p;

    // Hold stage control under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_p <= '0;
            r_ctl_x <= '0;
        end else begin
            if (w_en_p) begin
                r_ctl_p <= i_ctl;
            end
            if (w_en_x) begin
                r_ctl_x <= r_ctl_p;
            end
        end
    end

    // Register the six products
    always_ff @(posedge i_clk) begin
        if (w_en_p) begin
            r_c0 <= PW'(i_e0x) * PW'(i_e1y);
            r_c1 <= PW'(i_e0y) * PW'(i_e1x);
            r_a0 <= PW'(i_e2x) * PW'(i_e1y);
            r_a1 <= PW'(i_e2y) * PW'(i_e1x);
            r_b0 <= PW'(i_e0x) * PW'(i_e2y);
            r_b1 <= PW'(i_e0y) * PW'(i_e2x);
        end
    end

    // Form the crosses
    always_ff @(posedge i_clk) begin
        if (w_en_x) begin
            r_c <= CW'(r_c0) - CW'(r_c1);
            r_a <= CW'(r_a0) - CW'(r_a1);
            r_b <= CW'(r_b0) - CW'(r_b1);
        end
    end

    assign o_ctl = r_ctl_x;
    assign o_a   = r_a;
    assign o_b   = r_b;
    assign o_c   = r_c;
endmodule

/* design/pit_decide.sv */
// Stage 4: sign-aware containment decision into the output register.
`include "point_in_triangle_test_core_defines.svh"

module pit_decide #(
    parameter int COORD_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pit_pkg::t_stage_ctl             i_ctl,
    input  logic signed [2*COORD_BITS+2:0]  i_a,
    input  logic signed [2*COORD_BITS+2:0]  i_b,
    input  logic signed [2*COORD_BITS+2:0]  i_c,
    output logic                            o_ready,
    pit_out_if.source                       o_out
);
    localparam int CW = 2 * COORD_BITS + 3;
    localparam int SW = CW + 1;

    logic                 r_valid;
    logic                 r_inside;
    pit_pkg::t_status     r_status;
    logic                 n_inside;
    pit_pkg::t_status     n_status;
    logic signed [SW-1:0] w_sum;
    logic signed [SW-1:0] w_c_ext;
    logic                 w_en;

    assign w_en    = !r_valid || o_out.ready;
    assign o_ready = w_en;

    // Flag a height mismatch or zero area, else compare the cross products against the triangle's signed area
    always_comb begin
        w_sum   = SW'(i_a) + SW'(i_b);
        w_c_ext = SW'(i_c);
        n_inside = 1'b0;
        n_status = pit_pkg::STATUS_TESTED;
        priority if (i_ctl.z_diff) begin
            n_status = pit_pkg::STATUS_Z_DIFFER;
        end else if (i_c == '0) begin
            n_status = pit_pkg::STATUS_DEGENERATE;
        end else if (i_c > 0) begin
            n_inside = (i_a >= 0) && (i_b >= 0) && (w_sum <= w_c_ext);
        end else begin
            n_inside = (i_a <= 0) && (i_b <= 0) && (w_sum >= w_c_ext);
        end
    end

    // Hold the output valid under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_inside <= n_inside;
            r_status <= n_status;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.inside_res = r_inside;
    assign o_out.status     = r_status;

    `PIT_ASSERT(a_untested_is_outside, i_clk, i_rst_n, (r_valid && (r_status != pit_pkg::STATUS_TESTED)) |-> !r_inside, "untested transaction reported inside")
    `PIT_ASSERT(a_z_differ_status, i_clk, i_rst_n, (w_en && i_ctl.valid && i_ctl.z_diff) |=> (r_status == pit_pkg::STATUS_Z_DIFFER), "height mismatch not reported")
    `PIT_ASSERT(a_degenerate_status, i_clk, i_rst_n, (w_en && i_ctl.valid && !i_ctl.z_diff && (i_c == '0)) |=> (r_status == pit_pkg::STATUS_DEGENERATE), "degenerate triangle not reported")
    `PIT_ASSERT_ALWAYS(a_reset_clears_valid, i_clk, $past(!i_rst_n) |-> !r_valid, "output valid set after reset")
endmodule

/* design/point_in_triangle_test_core.sv */
// Point-in-triangle coverage test: four-stage pipeline, one transaction per cycle unless stalled.
//
// Input channel i_in carries three vertices (x, y, z) and a query point (x, y),
// each COORD_BITS wide, two's complement. Output channel o_out returns one
// transaction per input: inside_res (1 when inside or on an edge) and status
// (tested, vertex heights differ, degenerate triangle). Heights are checked
// for equality only; on mismatch or zero area inside_res is 0.
// Path: four registers (edge vectors, products, cross products, decision), the
// first one loaded at the input acceptance edge; o_out.valid is driven by the
// decision register.
// Throughput: one transaction per cycle sustained while o_out.ready stays high; the six
// cross-product multipliers are fully pipelined and each stage has its own valid bit.
// Stall: when o_out.ready is low the output register holds; upstream stages
// keep accepting until every stage is full, then i_in.ready drops. Nothing is
// lost or repeated.
// Reset: i_rst_n is synchronous, active low, and empties all stages; i_in.ready
// stays low while reset is held.
module point_in_triangle_test_core #(
    parameter int COORD_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pit_in_if.sink     i_in,
    pit_out_if.source  o_out
);
    pit_pkg::t_stage_ctl               w_ctl_d, w_ctl_m;
    logic signed [COORD_BITS:0]        w_e0x, w_e0y, w_e1x, w_e1y, w_e2x, w_e2y;
    logic signed [2*COORD_BITS+2:0]    w_a, w_b, w_c;
    logic                              w_ready_m, w_ready_d;

    // Edge vectors and height check
    pit_diff #(.COORD_BITS(COORD_BITS)) u_diff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ready (w_ready_m),
        .o_ctl   (w_ctl_d),
        .o_e0x   (w_e0x),
        .o_e0y   (w_e0y),
        .o_e1x   (w_e1x),
        .o_e1y   (w_e1y),
        .o_e2x   (w_e2x),
        .o_e2y   (w_e2y)
    );

    // Products and cross products
    pit_mult #(.COORD_BITS(COORD_BITS)) u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_d),
        .i_e0x   (w_e0x),
        .i_e0y   (w_e0y),
        .i_e1x   (w_e1x),
        .i_e1y   (w_e1y),
        .i_e2x   (w_e2x),
        .i_e2y   (w_e2y),
        .o_ready (w_ready_m),
        .i_ready (w_ready_d),
        .o_ctl   (w_ctl_m),
        .o_a     (w_a),
        .o_b     (w_b),
        .o_c     (w_c)
    );

    // Decision and output register
    pit_decide #(.COORD_BITS(COORD_BITS)) u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_m),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_c     (w_c),
        .o_ready (w_ready_d),
        .o_out   (o_out)
    );
endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the point-in-triangle coverage test pipeline.
module tb_top;

    localparam int CB = 16;

    // One triangle plus query point, as it travels on the input channel
    typedef struct packed {
        logic signed [CB-1:0] first_x;
        logic signed [CB-1:0] first_y;
        logic signed [CB-1:0] first_z;
        logic signed [CB-1:0] second_x;
        logic signed [CB-1:0] second_y;
        logic signed [CB-1:0] second_z;
        logic signed [CB-1:0] third_x;
        logic signed [CB-1:0] third_y;
        logic signed [CB-1:0] third_z;
        logic signed [CB-1:0] query_x;
        logic signed [CB-1:0] query_y;
    } t_tri;

    // Coverage verdict for one triangle
    typedef struct packed {
        logic             hit;
        pit_pkg::t_status status;
    } t_verdict;

    // Predict coverage verdicts and match them against returned transactions
    class coverage_board;
        t_verdict verdict_q[$];
        int       errors;
        int       checked;

        function new();
            errors  = 0;
            checked = 0;
        endfunction

        // Edge-inclusive barycentric test done exactly on cross products
        static function t_verdict predict_coverage(t_tri t);
            longint   e0x, e0y, e1x, e1y, e2x, e2y;
            longint   area, wa, wb;
            t_verdict v;
            v.hit    = 1'b0;
            v.status = pit_pkg::STATUS_TESTED;
            if (t.first_z != t.second_z || t.second_z != t.third_z) begin
                v.status = pit_pkg::STATUS_Z_DIFFER;
                return v;
            end
            e0x = longint'($signed(t.third_x))  - longint'($signed(t.first_x));
            e0y = longint'($signed(t.third_y))  - longint'($signed(t.first_y));
            e1x = longint'($signed(t.second_x)) - longint'($signed(t.first_x));
            e1y = longint'($signed(t.second_y)) - longint'($signed(t.first_y));
            e2x = longint'($signed(t.query_x))  - longint'($signed(t.first_x));
            e2y = longint'($signed(t.query_y))  - longint'($signed(t.first_y));
            area = e0x * e1y - e0y * e1x;
            if (area == 0) begin
                v.status = pit_pkg::STATUS_DEGENERATE;
                return v;
            end
            wa = e2x * e1y - e2y * e1x;
            wb = e0x * e2y - e0y * e2x;
            if (area > 0)
                v.hit = (wa >= 0) && (wb >= 0) && (wa + wb <= area);
            else
                v.hit = (wa <= 0) && (wb <= 0) && (wa + wb >= area);
            return v;
        endfunction

        function void note_triangle(t_tri t);
            verdict_q.push_back(predict_coverage(t));
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        // Compare one returned transaction with the oldest prediction
        task check_result(logic got_hit, logic [1:0] got_status);
            t_verdict want;
            if (verdict_q.size() == 0) begin
                report($sformatf("result %0d with nothing pending (hit=%b status=%0d)",
                                 checked, got_hit, got_status));
                checked++;
                return;
            end
            want = verdict_q.pop_front();
            if (got_hit !== want.hit)
                report($sformatf("result %0d inside_res got %b want %b",
                                 checked, got_hit, want.hit));
            if (got_status !== want.status)
                report($sformatf("result %0d status got %0d want %0d",
                                 checked, got_status, want.status));
            checked++;
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    pit_in_if #(.COORD_BITS(CB)) in_ch ();
    pit_out_if                   out_ch ();

    coverage_board board;

    point_in_triangle_test_core #(
        .COORD_BITS(CB)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Free-running clock, period 8
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Safety net against a hung pipeline
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    function automatic int rnd16();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int rnd_span(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic t_tri make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                      int cx, int cy, int cz, int qx, int qy);
        t_tri t;
        t.first_x  = ax[CB-1:0];
        t.first_y  = ay[CB-1:0];
        t.first_z  = az[CB-1:0];
        t.second_x = bx[CB-1:0];
        t.second_y = by[CB-1:0];
        t.second_z = bz[CB-1:0];
        t.third_x  = cx[CB-1:0];
        t.third_y  = cy[CB-1:0];
        t.third_z  = cz[CB-1:0];
        t.query_x  = qx[CB-1:0];
        t.query_y  = qy[CB-1:0];
        return t;
    endfunction

    // Place the query on a vertex, an edge, inside, or scattered near the triangle
    function automatic t_tri place_query(t_tri t, int spread);
        int vx[3];
        int vy[3];
        int i, j, w0, w1, w2, qx, qy;
        vx[0] = int'($signed(t.first_x));
        vy[0] = int'($signed(t.first_y));
        vx[1] = int'($signed(t.second_x));
        vy[1] = int'($signed(t.second_y));
        vx[2] = int'($signed(t.third_x));
        vy[2] = int'($signed(t.third_y));
        i = $urandom_range(0, 2);
        j = (i + 1 + $urandom_range(0, 1)) % 3;
        case ($urandom_range(0, 5))
            0: begin
                qx = vx[i];
                qy = vy[i];
            end
            1: begin
                qx = (vx[i] + vx[j]) / 2;
                qy = (vy[i] + vy[j]) / 2;
            end
            2, 3: begin
                w0 = $urandom_range(1, 15);
                w1 = $urandom_range(0, 15);
                w2 = $urandom_range(0, 15);
                qx = (w0 * vx[0] + w1 * vx[1] + w2 * vx[2]) / (w0 + w1 + w2);
                qy = (w0 * vy[0] + w1 * vy[1] + w2 * vy[2]) / (w0 + w1 + w2);
            end
            default: begin
                qx = vx[i] + rnd_span(spread);
                qy = vy[i] + rnd_span(spread);
            end
        endcase
        t.query_x = qx[CB-1:0];
        t.query_y = qy[CB-1:0];
        return t;
    endfunction

    // Mix of well-formed triangles, height mismatches, degenerate ones and noise
    function automatic t_tri random_triangle();
        int   kind, z, bx, by, dx, dy, k, m, r, sel;
        int   zs[3];
        t_tri t;
        kind = $urandom_range(0, 99);
        z    = rnd16();
        if (kind < 8) begin
            t = make_tri(rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
                         rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
        end else if (kind < 18) begin
            zs[0] = z;
            zs[1] = z;
            zs[2] = z;
            sel = $urandom_range(0, 2);
            zs[sel] = z + int'($urandom_range(1, 65535));
            bx = rnd16();
            by = rnd16();
            t = make_tri(bx, by, zs[0], bx + rnd_span(64), by + rnd_span(64), zs[1],
                         bx + rnd_span(64), by + rnd_span(64), zs[2], 0, 0);
            t = place_query(t, 64);
        end else if (kind < 28) begin
            bx = rnd16();
            by = rnd16();
            dx = rnd_span(200);
            dy = rnd_span(200);
            k  = rnd_span(8);
            m  = rnd_span(8);
            t = make_tri(bx, by, z, bx + k * dx, by + k * dy, z,
                         bx + m * dx, by + m * dy, z, 0, 0);
            t = place_query(t, 400);
        end else if (kind < 60) begin
            bx = rnd16();
            by = rnd16();
            r  = $urandom_range(1, 64);
            t = make_tri(bx, by, z, bx + rnd_span(r), by + rnd_span(r), z,
                         bx + rnd_span(r), by + rnd_span(r), z, 0, 0);
            t = place_query(t, 2 * r);
        end else if (kind < 85) begin
            t = make_tri(rnd16(), rnd16(), z, rnd16(), rnd16(), z,
                         rnd16(), rnd16(), z, 0, 0);
            t = place_query(t, 4096);
        end else begin
            t = make_tri(rnd16(), rnd16(), z, rnd16(), rnd16(), z,
                         rnd16(), rnd16(), z, rnd16(), rnd16());
        end
        return t;
    endfunction

    // Offer one transaction and hold it until the block takes it
    task send_item(input t_tri t);
        in_ch.valid    <= 1'b1;
        in_ch.first_x  <= t.first_x;
        in_ch.first_y  <= t.first_y;
        in_ch.first_z  <= t.first_z;
        in_ch.second_x <= t.second_x;
        in_ch.second_y <= t.second_y;
        in_ch.second_z <= t.second_z;
        in_ch.third_x  <= t.third_x;
        in_ch.third_y  <= t.third_y;
        in_ch.third_z  <= t.third_z;
        in_ch.query_x  <= t.query_x;
        in_ch.query_y  <= t.query_y;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_triangle(t);
    endtask

    // Drop valid for an idle gap and scramble the payload meanwhile
    task idle_cycles(input int n);
        if (n > 0) begin
            in_ch.valid    <= 1'b0;
            in_ch.first_x  <= CB'(rnd16());
            in_ch.second_y <= CB'(rnd16());
            in_ch.third_z  <= CB'(rnd16());
            in_ch.query_x  <= CB'(rnd16());
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stop offering until every predicted result has come back
    task drain_results();
        idle_cycles(1);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Receiver: check transactions and stall on its own pattern
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        int holds;
        int seen;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        holds     = 0;
        seen      = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                board.check_result(out_ch.inside_res, out_ch.status);
                seen++;
            end
            // Hold off for a long stretch twice so the pipeline fills and backs up
            if (hold_left == 0 && ((seen >= 300 && holds == 0) ||
                                   (seen >= 900 && holds == 1))) begin
                hold_left = 80;
                holds++;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 64);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 1) == 0);
                    2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= mode_left[0];
                endcase
            end
        end
    end

    // Sender: reset, directed cases, then random traffic in bursts
    initial begin
        int burst_left;
        int n;
        board = new();
        in_ch.valid    = 1'b0;
        in_ch.first_x  = '0;
        in_ch.first_y  = '0;
        in_ch.first_z  = '0;
        in_ch.second_x = '0;
        in_ch.second_y = '0;
        in_ch.second_z = '0;
        in_ch.third_x  = '0;
        in_ch.third_y  = '0;
        in_ch.third_z  = '0;
        in_ch.query_x  = '0;
        in_ch.query_y  = '0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Counter-clockwise right triangle: inside, vertex, edges, outside
        send_item(make_tri(0, 0, 0, 100, 0, 0, 0, 100, 0, 10, 10));
        send_item(make_tri(0, 0, 0, 100, 0, 0, 0, 100, 0, 0, 0));
        send_item(make_tri(0, 0, 0, 100, 0, 0, 0, 100, 0, 50, 50));
        send_item(make_tri(0, 0, 0, 100, 0, 0, 0, 100, 0, 50, 0));
        send_item(make_tri(0, 0, 0, 100, 0, 0, 0, 100, 0, 51, 50));
        send_item(make_tri(0, 0, 0, 100, 0, 0, 0, 100, 0, -1, 0));
        // Same triangle wound clockwise
        send_item(make_tri(0, 0, 7, 0, 100, 7, 100, 0, 7, 10, 10));
        send_item(make_tri(0, 0, 7, 0, 100, 7, 100, 0, 7, 101, 0));
        send_item(make_tri(0, 0, 7, 0, 100, 7, 100, 0, 7, 0, 100));
        // Height mismatch on each pair, and ahead of a degenerate shape
        send_item(make_tri(0, 0, 1, 100, 0, 2, 0, 100, 2, 10, 10));
        send_item(make_tri(0, 0, 5, 100, 0, 5, 0, 100, 6, 10, 10));
        send_item(make_tri(0, 0, -32768, 100, 0, 32767, 0, 100, -32768, 10, 10));
        send_item(make_tri(0, 0, 3, 0, 0, 4, 0, 0, 3, 0, 0));
        // Degenerate: all coincident, collinear, two coincident
        send_item(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_tri(0, 0, 0, 10, 10, 0, 20, 20, 0, 10, 10));
        send_item(make_tri(0, 0, 0, 0, 0, 0, 5, 7, 0, 1, 1));
        send_item(make_tri(-32768, 0, 0, 32767, 0, 0, 0, 0, 0, 0, 0));
        // Full-scale coordinates
        send_item(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                           -32768, 32767, -32768, -32768, -32768));
        send_item(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                           -32768, 32767, -32768, -1, 0));
        send_item(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                           -32768, 32767, -32768, 0, 0));
        send_item(make_tri(-32768, -32768, 32767, 32767, 32767, 32767,
                           32767, -32768, 32767, 0, -1));
        send_item(make_tri(-32768, -32768, 32767, 32767, 32767, 32767,
                           32767, -32768, 32767, -32768, 32767));
        send_item(make_tri(-1, -1, -1, -1, 0, -1, 0, -1, -1, -1, -1));

        // Random traffic in bursts with gaps
        burst_left = $urandom_range(1, 40);
        for (n = 0; n < 1300; n++) begin
            if (n == 700)
                drain_results();
            send_item(random_triangle());
            burst_left--;
            if (burst_left == 0) begin
                idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
                burst_left = $urandom_range(1, 40);
            end
        end

        // Wait out the pipeline, then settle for stray results
        drain_results();
        repeat (12) @(posedge i_clk);
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/pit_pkg.sv
design/pit_in_if.sv
design/pit_out_if.sv
design/pit_diff.sv
design/pit_mult.sv
design/pit_decide.sv
design/point_in_triangle_test_core.sv
tb/tb_top.sv
